// ===== hdl/bc_pkg.sv =====
`default_nettype none

package bc_pkg;

  localparam int MAX_NODES_DEF     = 64;
  localparam int FRACTION_BITS_DEF = 24;

  localparam int IDX_W   = 6;
  localparam int ROW_W   = 64;
  localparam int CFG_W   = 7;
  localparam int SCORE_W = 32;
  localparam int DIST_W  = 7;
  localparam int PATH_W  = 64;
  localparam int DEP_W   = 48;
  localparam int SCALE_W = 49;
  localparam int QUO_W   = 64;
  localparam int PROD_W  = SCALE_W + PATH_W;

  localparam int MIN_NODES      = 3;
  localparam int NODE_COUNT_RST = 64;

  localparam logic [DEP_W-1:0] DEP_MAX = '1;

  // request and response of the shared multiply-divide unit
  typedef struct packed {
    logic               start;
    logic [SCALE_W-1:0] a;
    logic [PATH_W-1:0]  b;
    logic [PATH_W-1:0]  d;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] q;
  } md_rsp_t;

  function automatic logic [DEP_W-1:0] sat_add_dep(logic [DEP_W-1:0] x, logic [QUO_W-1:0] y);
    logic [QUO_W:0] s;
    s = (QUO_W+1)'(x) + (QUO_W+1)'(y);
    return (s > (QUO_W+1)'(DEP_MAX)) ? DEP_MAX : s[DEP_W-1:0];
  endfunction

  function automatic logic [PATH_W-1:0] sat_add_path(logic [PATH_W-1:0] x,
                                                     logic [PATH_W-1:0] y);
    logic [PATH_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[PATH_W] ? '1 : s[PATH_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bc_muldiv.sv =====
`default_nettype none

module bc_muldiv import bc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  localparam int MUL_STEPS = 4;
  localparam int STEPS     = MUL_STEPS + PROD_W;
  localparam int SW        = $clog2(STEPS + 1);

  logic              busy_q, done_q;
  logic [SW-1:0]     step_q;
  logic [SCALE_W-1:0] a_q;
  logic [PATH_W-1:0] b_q, d_q, rem_q;
  logic [PROD_W-1:0] prod_q, pp_sh;
  logic [QUO_W-1:0]  quo_q;
  logic [31:0]       a_part, b_part;
  logic [63:0]       pp;
  logic [PATH_W:0]   t, diff;
  logic              ge, mul_phase;

  assign mul_phase = step_q < SW'(MUL_STEPS);

  // one 32x32 partial product per step
  always_comb begin
    a_part = step_q[0] ? 32'(a_q[SCALE_W-1:32]) : a_q[31:0];
    b_part = step_q[1] ? b_q[63:32] : b_q[31:0];
    pp     = a_part * b_part;
    case (step_q[1:0])
      2'd0:    pp_sh = PROD_W'(pp);
      2'd3:    pp_sh = PROD_W'(pp) << 64;
      default: pp_sh = PROD_W'(pp) << 32;
    endcase
  end

  // restoring division, one quotient bit per step
  assign t    = {rem_q, prod_q[PROD_W-1]};
  assign ge   = t >= {1'b0, d_q};
  assign diff = t - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + SW'(1);
        if (step_q == SW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q    <= req_i.a;
      b_q    <= req_i.b;
      d_q    <= req_i.d;
      prod_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      if (mul_phase) begin
        prod_q <= prod_q + pp_sh;
      end else begin
        prod_q <= prod_q << 1;
        rem_q  <= ge ? diff[PATH_W-1:0] : t[PATH_W-1:0];
        quo_q  <= {quo_q[QUO_W-2:0], ge};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;

endmodule

`default_nettype wire

// ===== hdl/betweenness_centrality_engine.sv =====
`default_nettype none

// Betweenness centrality engine. Adjacency rows are taken one per cycle; the row
// flagged last_row starts the run, and the input stalls until the last score has
// been loaded into the output register. For each source a breadth-first pass
// scans the row of every visited node, then an accumulation pass walks the
// visit order backwards and, per predecessor edge, uses the shared
// multiply-divide unit (4 partial-product steps, then 113 one-bit restoring
// division steps). Each score then passes through the same unit. Per-source
// state is invalidated by a visited vector, so no clearing pass is needed.
module betweenness_centrality_engine import bc_pkg::*; #(
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [IDX_W-1:0]   row_index_i,
  input  logic [ROW_W-1:0]   row_bits_i,
  input  logic               last_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IDX_W-1:0]   node_index_o,
  output logic [SCORE_W-1:0] score_o,
  output logic               last_score_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_data_i
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [SCALE_W-1:0] FIX_ONE = SCALE_W'(1) << FRACTION_BITS;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_HRD   = 5'd2;
  localparam logic [4:0] S_HV    = 5'd3;
  localparam logic [4:0] S_HV2   = 5'd4;
  localparam logic [4:0] S_SCAN  = 5'd5;
  localparam logic [4:0] S_UPD   = 5'd6;
  localparam logic [4:0] S_BRD   = 5'd7;
  localparam logic [4:0] S_BW    = 5'd8;
  localparam logic [4:0] S_BW2   = 5'd9;
  localparam logic [4:0] S_BSCAN = 5'd10;
  localparam logic [4:0] S_BMUL  = 5'd11;
  localparam logic [4:0] S_BDIV  = 5'd12;
  localparam logic [4:0] S_BACC  = 5'd13;
  localparam logic [4:0] S_NEXT  = 5'd14;
  localparam logic [4:0] S_ORD   = 5'd15;
  localparam logic [4:0] S_OW    = 5'd16;
  localparam logic [4:0] S_ODIV  = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  typedef struct packed {
    logic [DEP_W-1:0]     dep;
    logic [MAX_NODES-1:0] pred;
    logic [PATH_W-1:0]    path;
    logic [DIST_W-1:0]    hops;
  } rec_t;

  // memories
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  rec_t                 rec_mem [MAX_NODES];
  logic [AW-1:0]        ord_mem [MAX_NODES];
  logic [DEP_W-1:0]     acc_mem [MAX_NODES];

  logic                 adj_we, rec_we, ord_we, acc_we;
  logic [AW-1:0]        adj_wa, adj_ra, rec_wa, rec_ra, ord_wa, ord_ra, acc_wa, acc_ra;
  logic [MAX_NODES-1:0] adj_rd;
  rec_t                 rec_wd, rec_rd;
  logic [AW-1:0]        ord_wd, ord_rd;
  logic [DEP_W-1:0]     acc_wd, acc_rd;

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_wa] <= row_bits_i[MAX_NODES-1:0];
    adj_rd <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd <= acc_mem[acc_ra];
  end

  // control state
  logic [4:0]           state_q, state_d;
  logic [MAX_NODES-1:0] visited_q, visited_d, acc_vld_q, acc_vld_d;
  logic [CW-1:0]        n_q, n_d, s_q, s_d, head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]        w_q, w_d, u_q, u_d, i_q, i_d, k_q, k_d;
  logic                 out_valid_q, out_valid_d;
  logic [CFG_W-1:0]     node_count_q;

  // payload
  logic [AW-1:0]        v_q, v_d, wn_q, wn_d;
  logic [MAX_NODES-1:0] row_q, row_d, predm_q, predm_d;
  logic [DIST_W-1:0]    distv_q, distv_d;
  logic [PATH_W-1:0]    pathv_q, pathv_d, sw_q, sw_d;
  logic [SCALE_W-1:0]   scale_q, scale_d;
  logic [DEP_W-1:0]     depwn_q, depwn_d, accwn_q, accwn_d;
  rec_t                 recv_q, recv_d;
  logic [SCORE_W-1:0]   res_q, res_d;
  logic [IDX_W-1:0]     node_idx_q;
  logic [SCORE_W-1:0]   score_q;
  logic                 last_q;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic                 in_accept, out_load, row_in_range;
  logic [CFG_W-1:0]     n_clamp;
  logic [CW-1:0]        n_eff, nm1, im1;
  logic [2*CW-1:0]      denom;
  logic [AW-1:0]        widx, uidx, sidx, kidx;

  bc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign in_stall_o   = state_q != S_IDLE;
  assign in_accept    = in_valid_i && !in_stall_o;
  assign cfg_ready_o  = 1'b1;
  assign row_in_range = 7'(row_index_i) < 7'(MAX_NODES);

  always_comb begin
    if (node_count_q < CFG_W'(MIN_NODES)) n_clamp = CFG_W'(MIN_NODES);
    else if (node_count_q > CFG_W'(MAX_NODES)) n_clamp = CFG_W'(MAX_NODES);
    else n_clamp = node_count_q;
  end

  assign n_eff = CW'(n_clamp);
  assign nm1   = n_q - CW'(1);
  assign im1   = i_q - CW'(1);
  assign denom = (2*CW)'(nm1) * (2*CW)'(n_q - CW'(2));
  assign widx  = w_q[AW-1:0];
  assign uidx  = u_q[AW-1:0];
  assign sidx  = s_q[AW-1:0];
  assign kidx  = k_q[AW-1:0];

  assign adj_we = in_accept && row_in_range;
  assign adj_wa = row_index_i[AW-1:0];

  always_comb begin
    rec_t          upd_rec;
    logic [DIST_W-1:0] dist_next;

    upd_rec     = rec_rd;
    dist_next   = distv_q + DIST_W'(1);
    state_d     = state_q;
    visited_d   = visited_q;
    acc_vld_d   = acc_vld_q;
    n_d         = n_q;
    s_d         = s_q;
    head_d      = head_q;
    tail_d      = tail_q;
    w_d         = w_q;
    u_d         = u_q;
    i_d         = i_q;
    k_d         = k_q;
    v_d         = v_q;
    wn_d        = wn_q;
    row_d       = row_q;
    predm_d     = predm_q;
    distv_d     = distv_q;
    pathv_d     = pathv_q;
    sw_d        = sw_q;
    scale_d     = scale_q;
    depwn_d     = depwn_q;
    accwn_d     = accwn_q;
    recv_d      = recv_q;
    res_d       = res_q;
    out_load    = 1'b0;
    adj_ra      = '0;
    rec_we      = 1'b0;
    rec_wa      = '0;
    rec_wd      = rec_rd;
    rec_ra      = '0;
    ord_we      = 1'b0;
    ord_wa      = '0;
    ord_wd      = '0;
    ord_ra      = '0;
    acc_we      = 1'b0;
    acc_wa      = '0;
    acc_wd      = '0;
    acc_ra      = '0;
    md_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept && last_row_i) begin
          n_d       = n_eff;
          s_d       = '0;
          acc_vld_d = '0;
          state_d   = S_INIT;
        end
      end
      S_INIT: begin
        visited_d = MAX_NODES'(1) << sidx;
        rec_we    = 1'b1;
        rec_wa    = sidx;
        rec_wd    = '{dep: '0, pred: '0, path: PATH_W'(1), hops: '0};
        ord_we    = 1'b1;
        ord_wa    = '0;
        ord_wd    = sidx;
        head_d    = '0;
        tail_d    = CW'(1);
        state_d   = S_HRD;
      end
      S_HRD: begin
        if (head_q == tail_q) begin
          i_d     = tail_q;
          state_d = S_BRD;
        end else begin
          ord_ra  = head_q[AW-1:0];
          state_d = S_HV;
        end
      end
      S_HV: begin
        v_d     = ord_rd;
        adj_ra  = ord_rd;
        rec_ra  = ord_rd;
        state_d = S_HV2;
      end
      S_HV2: begin
        // drop self-loops
        row_d   = adj_rd & ~(MAX_NODES'(1) << v_q);
        distv_d = rec_rd.hops;
        pathv_d = rec_rd.path;
        w_d     = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (w_q == n_q) begin
          head_d  = head_q + CW'(1);
          state_d = S_HRD;
        end else if (row_q[widx]) begin
          rec_ra  = widx;
          state_d = S_UPD;
        end else begin
          w_d = w_q + CW'(1);
        end
      end
      S_UPD: begin
        if (!visited_q[widx]) begin
          upd_rec         = '0;
          upd_rec.hops    = dist_next;
          visited_d[widx] = 1'b1;
          ord_we          = 1'b1;
          ord_wa          = tail_q[AW-1:0];
          ord_wd          = widx;
          tail_d          = tail_q + CW'(1);
        end
        if (upd_rec.hops == dist_next) begin
          upd_rec.pred[v_q] = 1'b1;
          upd_rec.path      = sat_add_path(upd_rec.path, pathv_q);
        end
        rec_we  = 1'b1;
        rec_wa  = widx;
        rec_wd  = upd_rec;
        w_d     = w_q + CW'(1);
        state_d = S_SCAN;
      end
      S_BRD: begin
        if (i_q == '0) begin
          state_d = S_NEXT;
        end else begin
          ord_ra  = im1[AW-1:0];
          state_d = S_BW;
        end
      end
      S_BW: begin
        wn_d    = ord_rd;
        rec_ra  = ord_rd;
        acc_ra  = ord_rd;
        state_d = S_BW2;
      end
      S_BW2: begin
        scale_d = FIX_ONE + SCALE_W'(rec_rd.dep);
        sw_d    = rec_rd.path;
        predm_d = rec_rd.pred;
        depwn_d = rec_rd.dep;
        accwn_d = acc_vld_q[wn_q] ? acc_rd : '0;
        u_d     = '0;
        state_d = S_BSCAN;
      end
      S_BSCAN: begin
        if (u_q == n_q) begin
          state_d = S_BACC;
        end else if (predm_q[uidx]) begin
          rec_ra  = uidx;
          state_d = S_BMUL;
        end else begin
          u_d = u_q + CW'(1);
        end
      end
      S_BMUL: begin
        recv_d = rec_rd;
        if (sw_q == '0) begin
          // zero divisor adds nothing
          rec_we  = 1'b1;
          rec_wa  = uidx;
          rec_wd  = rec_rd;
          u_d     = u_q + CW'(1);
          state_d = S_BSCAN;
        end else begin
          md_req.start = 1'b1;
          md_req.a     = scale_q;
          md_req.b     = rec_rd.path;
          md_req.d     = sw_q;
          state_d      = S_BDIV;
        end
      end
      S_BDIV: begin
        if (md_rsp.done) begin
          upd_rec     = recv_q;
          upd_rec.dep = sat_add_dep(recv_q.dep, md_rsp.q);
          rec_we      = 1'b1;
          rec_wa      = uidx;
          rec_wd      = upd_rec;
          u_d         = u_q + CW'(1);
          state_d     = S_BSCAN;
        end
      end
      S_BACC: begin
        if (wn_q != sidx) begin
          acc_we          = 1'b1;
          acc_wa          = wn_q;
          acc_wd          = sat_add_dep(accwn_q, QUO_W'(depwn_q));
          acc_vld_d[wn_q] = 1'b1;
        end
        i_d     = im1;
        state_d = S_BRD;
      end
      S_NEXT: begin
        if (s_q == nm1) begin
          k_d     = '0;
          state_d = S_ORD;
        end else begin
          s_d     = s_q + CW'(1);
          state_d = S_INIT;
        end
      end
      S_ORD: begin
        acc_ra  = kidx;
        state_d = S_OW;
      end
      S_OW: begin
        md_req.start = 1'b1;
        md_req.a     = acc_vld_q[kidx] ? SCALE_W'(acc_rd) : '0;
        md_req.b     = PATH_W'(1);
        md_req.d     = PATH_W'(denom);
        state_d      = S_ODIV;
      end
      S_ODIV: begin
        if (md_rsp.done) begin
          res_d   = (|md_rsp.q[QUO_W-1:SCORE_W]) ? '1 : md_rsp.q[SCORE_W-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (k_q == nm1) begin
            state_d = S_IDLE;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      visited_q    <= '0;
      acc_vld_q    <= '0;
      n_q          <= CW'(MAX_NODES);
      s_q          <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      w_q          <= '0;
      u_q          <= '0;
      i_q          <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
      node_count_q <= CFG_W'(NODE_COUNT_RST);
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      acc_vld_q   <= acc_vld_d;
      n_q         <= n_d;
      s_q         <= s_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      w_q         <= w_d;
      u_q         <= u_d;
      i_q         <= i_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) node_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    wn_q    <= wn_d;
    row_q   <= row_d;
    predm_q <= predm_d;
    distv_q <= distv_d;
    pathv_q <= pathv_d;
    sw_q    <= sw_d;
    scale_q <= scale_d;
    depwn_q <= depwn_d;
    accwn_q <= accwn_d;
    recv_q  <= recv_d;
    res_q   <= res_d;
    if (out_load) begin
      node_idx_q <= IDX_W'(k_q);
      score_q    <= res_q;
      last_q     <= k_q == nm1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_index_o = node_idx_q;
  assign score_o      = score_q;
  assign last_score_o = last_q;

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_INIT) |-> tail_q <= n_q)
    else $error("visit order grew past node count");

  a_md_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> (state_q == S_BDIV || state_q == S_ODIV))
    else $error("multiply-divide result with no waiting consumer");

  a_src_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HRD |-> visited_q[sidx])
    else $error("source not marked visited during search");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result raised outside the output step");

endmodule

`default_nettype wire

// ===== test/tb_betweenness_centrality_engine.sv =====
`timescale 1ns / 1ps

module tb_betweenness_centrality_engine;
  import bc_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [ROW_W-1:0] bits;
    logic             last;
  } row_item_t;

  typedef struct {
    logic [IDX_W-1:0]   node;
    logic [SCORE_W-1:0] score;
    logic               last;
  } score_t;

  localparam int WATCHDOG_LIMIT = 3000000;
  localparam logic [63:0] FIX_ONE = 64'd1 << FRACTION_BITS_DEF;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [IDX_W-1:0]   row_index_i;
  logic [ROW_W-1:0]   row_bits_i;
  logic               last_row_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IDX_W-1:0]   node_index_o;
  logic [SCORE_W-1:0] score_o;
  logic               last_score_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_data_i;

  betweenness_centrality_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .row_index_i  (row_index_i),
    .row_bits_i   (row_bits_i),
    .last_row_i   (last_row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .node_index_o (node_index_o),
    .score_o      (score_o),
    .last_score_o (last_score_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  row_item_t   pending_rows[$];
  score_t      score_q[$];
  logic [63:0] adj_rows[64];
  logic [6:0]  node_count_reg;
  idle_mode_e  idle_mode;
  int          hold_cycles;
  int          mismatches;
  int          quiet_cycles;
  logic        row_taken;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {17'd0, a} + {1'b0, b};
    return (s > 65'h0_0000_FFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  // Brandes from every source over the first n nodes, then queue one score per node
  function automatic void predict_scores();
    int          n, head, tail, s, i, v, w, wn;
    logic [63:0] colmask, visited, row, sw, sum, denom, q;
    logic [6:0]  hops[64];
    logic [63:0] paths[64];
    logic [63:0] preds[64];
    int          order[64];
    logic [47:0] dep[64];
    logic [47:0] acc[64];
    logic [48:0] scale;
    logic [127:0] prod;
    score_t      r;
    n = node_count_reg;
    if (n < MIN_NODES) n = MIN_NODES;
    if (n > 64) n = 64;
    colmask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    for (i = 0; i < 64; i++) acc[i] = '0;
    for (s = 0; s < n; s++) begin
      for (i = 0; i < 64; i++) begin
        hops[i] = '0; paths[i] = '0; preds[i] = '0; dep[i] = '0;
      end
      visited = 64'd1 << s;
      paths[s] = 64'd1;
      head = 0; tail = 0;
      order[tail++] = s;
      while (head < tail) begin
        v = order[head++];
        row = adj_rows[v] & colmask & ~(64'd1 << v);
        for (w = 0; w < n; w++) begin
          if (!row[w]) continue;
          if (!visited[w]) begin
            visited[w] = 1'b1;
            hops[w] = hops[v] + 7'd1;
            if (tail < 64) order[tail++] = w;
          end
          if (hops[w] == 7'(hops[v] + 7'd1)) begin
            preds[w][v] = 1'b1;
            sum = paths[w] + paths[v];
            paths[w] = (sum < paths[w]) ? '1 : sum;
          end
        end
      end
      for (i = tail; i > 0; i--) begin
        wn = order[i-1];
        scale = {1'b0, FIX_ONE[47:0]} + {1'b0, dep[wn]};
        sw = paths[wn];
        for (v = 0; v < n; v++) begin
          if (!preds[wn][v]) continue;
          if (sw == 0) begin
            q = '0;
          end else begin
            prod = 128'(scale) * 128'(paths[v]);
            q = 64'(prod / 128'(sw));
          end
          dep[v] = sat_add48(dep[v], q);
        end
        if (wn != s) acc[wn] = sat_add48(acc[wn], {16'd0, dep[wn]});
      end
    end
    denom = 64'((n - 1) * (n - 2));
    for (i = 0; i < n; i++) begin
      q = {16'd0, acc[i]} / denom;
      r.node = IDX_W'(i);
      r.score = (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
      r.last = (i == n - 1);
      score_q.push_back(r);
    end
  endfunction

  // row feeder
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      row_index_i <= '0;
      row_bits_i <= '0;
      last_row_i <= 1'b0;
    end else if (!in_valid_i || row_taken) begin
      if (pending_rows.size() > 0 &&
          !((idle_mode == IDLE_SEND && $urandom_range(99) < 88) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 22))) begin
        row_item_t it;
        it = pending_rows[0];
        pending_rows.delete(0);
        in_valid_i <= 1'b1;
        row_index_i <= it.row;
        row_bits_i <= it.bits;
        last_row_i <= it.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // score receiver stall
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= (idle_mode == IDLE_RECV && $urandom_range(99) < 88) ||
                     (idle_mode == IDLE_BOTH && $urandom_range(99) < 22);
    end
  end

  always @(posedge clk_i) begin
    row_taken <= 1'b0;
    if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (in_valid_i && !in_stall_o) begin
        row_taken <= 1'b1;
        quiet_cycles <= 0;
        adj_rows[row_index_i] = row_bits_i;
        if (last_row_i) predict_scores();
      end
      if (cfg_valid_i && cfg_ready_o) begin
        quiet_cycles <= 0;
        node_count_reg = cfg_data_i;
      end
      if (out_valid_o && !out_stall_i) begin
        score_t e;
        quiet_cycles <= 0;
        if (score_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected score: node %0d score %h last %b",
                     node_index_o, score_o, last_score_o);
        end else begin
          e = score_q[0];
          score_q.delete(0);
          if (e.node !== node_index_o || e.score !== score_o || e.last !== last_score_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("score mismatch: exp node %0d score %h last %b, got %0d %h %b",
                       e.node, e.score, e.last, node_index_o, score_o, last_score_o);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_row(int density);
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case (density)
      0: return a & b;
      1: return a;
      default: return a | b;
    endcase
  endfunction

  function automatic void queue_row(int idx, logic [63:0] bits, logic last);
    row_item_t it;
    it.row = IDX_W'(idx);
    it.bits = bits;
    it.last = last;
    pending_rows.push_back(it);
  endfunction

  // a 64-node graph with at most one edge per row keeps the run short
  task automatic queue_sparse_graph(int rows);
    int r;
    for (r = 0; r < rows; r++)
      queue_row(r, ($urandom_range(2) == 0) ? 64'd0 : (64'd1 << $urandom_range(63)),
                r == rows - 1);
  endtask

  task automatic wait_drained();
    while (pending_rows.size() > 0 || in_valid_i || score_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [6:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_random_graph(int n);
    int k, r;
    k = $urandom_range(3);
    for (r = 0; r < k; r++)
      queue_row(($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(n - 1),
                rand_row($urandom_range(2)), 1'b0);
    queue_row(($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(n - 1),
              rand_row($urandom_range(2)), 1'b1);
  endtask

  initial begin
    int ph, g, n;
    logic [6:0] cv;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    idle_mode = IDLE_NONE;
    hold_cycles = 0;
    mismatches = 0;
    quiet_cycles = 0;
    node_count_reg = 7'(NODE_COUNT_RST);
    for (int i = 0; i < 64; i++) adj_rows[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset node count: full 64-node sparse graph writes every row once
    queue_sparse_graph(64);
    wait_drained();

    // below minimum acts as three nodes; full rows carry self-loops and far columns
    write_node_count(7'd0);
    queue_row(0, '1, 1'b0);
    queue_row(1, '1, 1'b0);
    queue_row(63, '1, 1'b0);
    queue_row(2, '1, 1'b1);
    queue_row(1, 64'd0, 1'b1);
    wait_drained();
    write_node_count(7'd2);
    queue_row(0, 64'h2, 1'b0);
    queue_row(1, 64'h4, 1'b0);
    queue_row(2, 64'hFFFF_FFFF_FFFF_FFF9, 1'b1);
    wait_drained();
    write_node_count(7'd3);
    queue_row(0, 64'd0, 1'b0);
    queue_row(1, 64'd0, 1'b0);
    queue_row(2, 64'd0, 1'b1);
    wait_drained();

    // random phases, one per idle mode
    for (ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      cv = ($urandom_range(4) == 0) ? 7'($urandom_range(2)) : 7'($urandom_range(3, 7));
      write_node_count(cv);
      n = (cv < 3) ? 3 : cv;
      if (ph == 1) hold_cycles = 3000;
      for (g = 0; g < 6; g++) begin
        queue_random_graph(n);
        // one pause until every score is in
        if (g == 3) while (pending_rows.size() > 0 || in_valid_i || score_q.size() > 0)
          @(posedge clk_i);
      end
      wait_drained();
    end

    // above maximum acts as 64 nodes; the other rows keep what earlier tests wrote
    idle_mode = IDLE_NONE;
    write_node_count(7'd127);
    queue_row(5, 64'd1 << 9, 1'b0);
    queue_row(63, 64'd1, 1'b1);
    wait_drained();

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && score_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
